>>> design/lti_pkg.sv
`timescale 1ns / 1ps

package lti_pkg;

    localparam int DATA_W      = 64;
    localparam int IDX_W       = 12;
    localparam int CFG_W       = 13;
    localparam int STENCIL_W   = 4;
    localparam int STATUS_W    = 2;
    localparam int NUM_VALS    = 6;
    localparam int S_TDATA_W   = 528;
    localparam int M_TDATA_W   = 384;
    localparam int PROD_W      = 128;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_POINTS  = 1'b0;
    localparam logic CFG_STENCIL = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BRACKET = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STENCIL = 2'd2;

    localparam logic signed [DATA_W-1:0] FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE,
        S_LAST_CHK,
        S_FIRST_CHK,
        S_BIS,
        S_BIS_CHK,
        S_PLACE,
        S_START,
        S_XI_RD,
        S_XI,
        S_XJ_RD,
        S_XJ,
        S_NUMDONE,
        S_DENDONE,
        S_WDONE,
        S_VAL,
        S_ACC,
        S_ACCDONE,
        S_EXT1,
        S_EXT2,
        S_EXT3,
        S_EXT4,
        S_EXT5,
        S_MPREP,
        S_MUL,
        S_MFIN,
        S_DPREP,
        S_DIV,
        S_DFIN,
        S_OUT
    } lti_state_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W-1:0] s;
        s = a + b;
        if (a[DATA_W-1] == b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
            return a[DATA_W-1] ? FX_MIN : FX_MAX;
        return s;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W-1:0] s;
        s = a - b;
        if (a[DATA_W-1] != b[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
            return a[DATA_W-1] ? FX_MIN : FX_MAX;
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] a);
        return a[DATA_W-1] ? (~a + 64'd1) : a;
    endfunction

    // Saturate an unsigned magnitude back into the signed range.
    function automatic logic signed [DATA_W-1:0] from_mag(
        input logic             neg,
        input logic [PROD_W-1:0] m
    );
        logic big;
        big = (m[PROD_W-1:DATA_W-1] != '0);
        if (neg)
            return big ? FX_MIN : -$signed(m[DATA_W-1:0]);
        return big ? FX_MAX : $signed(m[DATA_W-1:0]);
    endfunction

endpackage

>>> design/lagrange_table_interpolator.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: entry fields, s_tuser: op (0 load, 1 query)
// m_       out  m_tvalid/m_tready  m_tdata: six results, m_tuser: status
// cfg_     in   cfg_we             cfg_addr: register index, cfg_data: value
//
// A load item is written to the table as it is accepted, if its index lies within the table.
// A query runs a bracket search, then per stencil point i of a stencil of size s: 2*(s-1)
// multiplies, one divide and 6 multiplies. The exterior case costs two multiplies and three divides.
// The divider, retiring one quotient bit a cycle, sets the pace.
// Reset clears the sequencer and the configuration registers; the table has no reset and must be loaded.
// s_tready is low from a query's acceptance until its result item is taken.

module lagrange_table_interpolator
    import lti_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_STENCIL = 12,
    parameter int FRAC_BITS   = 40
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index, query_radius, entry_radius, entry_energy_density,
    // entry_baryon_density, entry_pressure, entry_mass, entry_lapse_squared,
    // entry_conformal_factor, zero fill
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,   // op
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // energy_density, baryon_density, pressure_out, enclosed_mass,
    // lapse_squared, conformal_factor
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic [STATUS_W-1:0]    m_tuser,   // status
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(MAX_STENCIL + 1);
    localparam logic signed [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0]         HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

    // Input field unpacking
    logic [IDX_W-1:0]         in_index;
    logic signed [DATA_W-1:0] in_query;
    logic [DATA_W-1:0]        in_ent [7];
    assign in_index = s_tdata[IDX_W-1:0];
    assign in_query = $signed(s_tdata[IDX_W +: DATA_W]);
    for (genvar g = 0; g < 7; g++) begin : g_unpack
        assign in_ent[g] = s_tdata[IDX_W + DATA_W*(g+1) +: DATA_W];
    end

    // Configuration registers
    logic [CFG_W-1:0]     points_reg;
    logic [STENCIL_W-1:0] stencil_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg  <= CFG_W'(2);
            stencil_reg <= STENCIL_W'(4);
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_POINTS)
                points_reg <= cfg_data;
            else
                stencil_reg <= cfg_data[STENCIL_W-1:0];
        end
    end

    // Entry count clamped to the table
    logic [31:0]   n_wide;
    logic [NW-1:0] n_eff;
    always_comb
    begin
        n_wide = 32'(points_reg);
        if (n_wide < 32'd2)
            n_wide = 32'd2;
        else if (n_wide > 32'(TABLE_DEPTH))
            n_wide = 32'(TABLE_DEPTH);
        n_eff = NW'(n_wide);
    end

    // Sequencer state
    lti_state_t state_reg, state_next, ret_reg, ret_next;

    logic signed [DATA_W-1:0] r_reg, r_next;
    logic signed [DATA_W-1:0] m_reg, m_next;
    logic signed [DATA_W-1:0] x_lo_reg, x_lo_next, x_hi_reg, x_hi_next;
    logic signed [DATA_W-1:0] xi_reg, xi_next, d2_reg, d2_next;
    logic signed [DATA_W-1:0] num_reg, num_next, den_reg, den_next;
    logic signed [DATA_W-1:0] w_reg, w_next;
    logic signed [DATA_W-1:0] vals_reg [NUM_VALS];
    logic signed [DATA_W-1:0] vals_next [NUM_VALS];
    logic signed [DATA_W-1:0] sums_reg [NUM_VALS];
    logic signed [DATA_W-1:0] sums_next [NUM_VALS];
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [AW-1:0]            lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [AW-1:0]            near_reg, near_next, start_reg, start_next;
    logic                     slo_gt_reg, slo_gt_next, slo_lt_reg, slo_lt_next;
    logic [SW-1:0]            i_reg, i_next, j_reg, j_next;
    logic [2:0]               k_reg, k_next;

    // Shared multiply / divide unit
    logic signed [DATA_W-1:0] op_a_reg, op_a_next, op_b_reg, op_b_next;
    logic signed [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W-1:0]        ua_reg, ua_next, ub_reg, ub_next, rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic [PROD_W-1:0]        acc_reg, acc_next, numsh_reg, numsh_next;
    logic [6:0]               cnt_reg, cnt_next;

    // Table memories
    logic [DATA_W-1:0] radius_mem    [TABLE_DEPTH];
    logic [DATA_W-1:0] energy_mem    [TABLE_DEPTH];
    logic [DATA_W-1:0] baryon_mem    [TABLE_DEPTH];
    logic [DATA_W-1:0] pressure_mem  [TABLE_DEPTH];
    logic [DATA_W-1:0] mass_mem      [TABLE_DEPTH];
    logic [DATA_W-1:0] lapse_mem     [TABLE_DEPTH];
    logic [DATA_W-1:0] conformal_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] rd_radius, rd_mass;
    logic [DATA_W-1:0]        rd_val [NUM_VALS];
    logic [AW-1:0]            rd_addr, wr_addr;
    logic                     mem_we;

    assign wr_addr = AW'(32'(in_index));
    assign mem_we  = s_tvalid && s_tready && (s_tuser == OP_LOAD)
                     && (32'(in_index) < 32'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            radius_mem[wr_addr]    <= in_ent[0];
            energy_mem[wr_addr]    <= in_ent[1];
            baryon_mem[wr_addr]    <= in_ent[2];
            pressure_mem[wr_addr]  <= in_ent[3];
            mass_mem[wr_addr]      <= in_ent[4];
            lapse_mem[wr_addr]     <= in_ent[5];
            conformal_mem[wr_addr] <= in_ent[6];
        end
        rd_radius <= $signed(radius_mem[rd_addr]);
        rd_mass   <= $signed(mass_mem[rd_addr]);
        rd_val[0] <= energy_mem[rd_addr];
        rd_val[1] <= baryon_mem[rd_addr];
        rd_val[2] <= pressure_mem[rd_addr];
        rd_val[3] <= mass_mem[rd_addr];
        rd_val[4] <= lapse_mem[rd_addr];
        rd_val[5] <= conformal_mem[rd_addr];
    end

    // Combinational helpers
    logic [AW:0]              mid_sum;
    logic                     smid_gt, smid_lt;
    logic [DATA_W-1:0]        dist_lo, dist_hi;
    logic signed [31:0]       st_wide, st_upper;
    logic [DATA_W-1:0]        pa, pb;
    logic [PROD_W-1:0]        pp;
    logic [DATA_W:0]          rem_sh;
    logic [PROD_W-1:0]        rounded;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign smid_gt = r_reg > rd_radius;
    assign smid_lt = r_reg < rd_radius;
    assign dist_lo = (r_reg >= x_lo_reg) ? (r_reg - x_lo_reg) : (x_lo_reg - r_reg);
    assign dist_hi = (r_reg >= x_hi_reg) ? (r_reg - x_hi_reg) : (x_hi_reg - r_reg);
    assign st_wide  = $signed(32'(near_reg)) - $signed(32'(stencil_reg >> 1)) - 32'sd1;
    assign st_upper = $signed(32'(n_eff)) - $signed(32'(stencil_reg));
    assign pa = cnt_reg[0] ? DATA_W'(ua_reg[DATA_W-1:32]) : DATA_W'(ua_reg[31:0]);
    assign pb = cnt_reg[1] ? DATA_W'(ub_reg[DATA_W-1:32]) : DATA_W'(ub_reg[31:0]);
    assign rem_sh  = {rem_reg, numsh_reg[PROD_W-1]};
    assign rounded = (acc_reg + HALF_LSB) >> FRAC_BITS;

    always_comb
    begin
        pp = PROD_W'(pa * pb);
        case (cnt_reg[1:0])
            2'd0:    pp = pp;
            2'd3:    pp = pp << 64;
            default: pp = pp << 32;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        r_reg      <= r_next;
        m_reg      <= m_next;
        x_lo_reg   <= x_lo_next;
        x_hi_reg   <= x_hi_next;
        xi_reg     <= xi_next;
        d2_reg     <= d2_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        w_reg      <= w_next;
        vals_reg   <= vals_next;
        sums_reg   <= sums_next;
        status_reg <= status_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        near_reg   <= near_next;
        start_reg  <= start_next;
        slo_gt_reg <= slo_gt_next;
        slo_lt_reg <= slo_lt_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        res_reg    <= res_next;
        ua_reg     <= ua_next;
        ub_reg     <= ub_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        numsh_reg  <= numsh_next;
        cnt_reg    <= cnt_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        r_next      = r_reg;
        m_next      = m_reg;
        x_lo_next   = x_lo_reg;
        x_hi_next   = x_hi_reg;
        xi_next     = xi_reg;
        d2_next     = d2_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        w_next      = w_reg;
        vals_next   = vals_reg;
        sums_next   = sums_reg;
        status_next = status_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        near_next   = near_reg;
        start_next  = start_reg;
        slo_gt_next = slo_gt_reg;
        slo_lt_next = slo_lt_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        op_a_next   = op_a_reg;
        op_b_next   = op_b_reg;
        res_next    = res_reg;
        ua_next     = ua_reg;
        ub_next     = ub_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        numsh_next  = numsh_reg;
        cnt_next    = cnt_reg;
        rd_addr     = AW'(n_eff - NW'(1));
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                // read the surface entry while waiting
                if (s_tvalid && s_tuser == OP_QUERY)
                begin
                    if (in_query[DATA_W-1])
                        r_next = (in_query == FX_MIN) ? FX_MAX : -in_query;
                    else
                        r_next = in_query;
                    for (int v = 0; v < NUM_VALS; v++)
                        sums_next[v] = '0;
                    status_next = STAT_OK;
                    state_next  = S_LAST_CHK;
                end
            end

            S_LAST_CHK:
            begin
                x_hi_next = rd_radius;
                m_next    = rd_mass;
                if (r_reg >= rd_radius)
                begin
                    // exterior: m*m first, keep 4r for the divide
                    d2_next    = sat_add(sat_add(r_reg, r_reg), sat_add(r_reg, r_reg));
                    op_a_next  = rd_mass;
                    op_b_next  = rd_mass;
                    ret_next   = S_EXT1;
                    state_next = S_MPREP;
                end
                else
                begin
                    rd_addr    = '0;
                    state_next = S_FIRST_CHK;
                end
            end

            S_FIRST_CHK:
            begin
                if (r_reg < rd_radius)
                begin
                    status_next = STAT_BRACKET;
                    state_next  = S_OUT;
                end
                else
                begin
                    x_lo_next   = rd_radius;
                    slo_gt_next = r_reg > rd_radius;
                    slo_lt_next = 1'b0;
                    lo_next     = '0;
                    hi_next     = AW'(n_eff - NW'(1));
                    state_next  = S_BIS;
                end
            end

            S_BIS:
            begin
                if ((hi_reg - lo_reg) > AW'(1))
                begin
                    mid_next   = mid_sum[AW:1];
                    rd_addr    = mid_sum[AW:1];
                    state_next = S_BIS_CHK;
                end
                else
                    state_next = S_PLACE;
            end

            S_BIS_CHK:
            begin
                if ((smid_gt && slo_gt_reg) || (smid_lt && slo_lt_reg))
                begin
                    lo_next     = mid_reg;
                    x_lo_next   = rd_radius;
                    slo_gt_next = smid_gt;
                    slo_lt_next = smid_lt;
                end
                else
                begin
                    hi_next   = mid_reg;
                    x_hi_next = rd_radius;
                end
                state_next = S_BIS;
            end

            S_PLACE:
            begin
                near_next  = (dist_lo < dist_hi) ? lo_reg : hi_reg;
                state_next = S_START;
            end

            S_START:
            begin
                if (32'(stencil_reg) > 32'(MAX_STENCIL) || 32'(stencil_reg) > 32'(n_eff))
                begin
                    status_next = STAT_STENCIL;
                    state_next  = S_OUT;
                end
                else if (stencil_reg == '0)
                    state_next = S_OUT;
                else
                begin
                    if (st_wide < 32'sd0)
                        start_next = '0;
                    else if (st_wide > st_upper)
                        start_next = AW'(st_upper);
                    else
                        start_next = AW'(st_wide);
                    i_next     = '0;
                    state_next = S_XI_RD;
                end
            end

            S_XI_RD:
            begin
                rd_addr    = AW'(32'(start_reg) + 32'(i_reg));
                state_next = S_XI;
            end

            S_XI:
            begin
                xi_next    = rd_radius;
                num_next   = FX_ONE;
                den_next   = FX_ONE;
                j_next     = '0;
                state_next = S_XJ_RD;
            end

            S_XJ_RD:
            begin
                if (32'(j_reg) == 32'(stencil_reg))
                begin
                    op_a_next  = num_reg;
                    op_b_next  = den_reg;
                    ret_next   = S_WDONE;
                    state_next = S_DPREP;
                end
                else if (j_reg == i_reg)
                    j_next = j_reg + SW'(1);
                else
                begin
                    rd_addr    = AW'(32'(start_reg) + 32'(j_reg));
                    state_next = S_XJ;
                end
            end

            S_XJ:
            begin
                op_a_next  = num_reg;
                op_b_next  = sat_sub(r_reg, rd_radius);
                d2_next    = sat_sub(xi_reg, rd_radius);
                ret_next   = S_NUMDONE;
                state_next = S_MPREP;
            end

            S_NUMDONE:
            begin
                num_next   = res_reg;
                op_a_next  = den_reg;
                op_b_next  = d2_reg;
                ret_next   = S_DENDONE;
                state_next = S_MPREP;
            end

            S_DENDONE:
            begin
                den_next   = res_reg;
                j_next     = j_reg + SW'(1);
                state_next = S_XJ_RD;
            end

            S_WDONE:
            begin
                w_next     = res_reg;
                rd_addr    = AW'(32'(start_reg) + 32'(i_reg));
                state_next = S_VAL;
            end

            S_VAL:
            begin
                for (int v = 0; v < NUM_VALS; v++)
                    vals_next[v] = $signed(rd_val[v]);
                k_next     = '0;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                op_a_next  = w_reg;
                op_b_next  = vals_reg[k_reg];
                ret_next   = S_ACCDONE;
                state_next = S_MPREP;
            end

            S_ACCDONE:
            begin
                sums_next[k_reg] = sat_add(sums_reg[k_reg], res_reg);
                if (k_reg == 3'(NUM_VALS - 1))
                begin
                    if (32'(i_reg) + 32'd1 == 32'(stencil_reg))
                        state_next = S_OUT;
                    else
                    begin
                        i_next     = i_reg + SW'(1);
                        state_next = S_XI_RD;
                    end
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_ACC;
                end
            end

            S_EXT1:
            begin
                op_a_next  = res_reg;
                op_b_next  = d2_reg;
                ret_next   = S_EXT2;
                state_next = S_DPREP;
            end

            S_EXT2:
            begin
                // rs = (r + M) + M*M/(4r)
                xi_next    = sat_add(sat_add(r_reg, m_reg), res_reg);
                op_a_next  = sat_add(sat_add(r_reg, m_reg), res_reg);
                op_b_next  = r_reg;
                ret_next   = S_EXT3;
                state_next = S_DPREP;
            end

            S_EXT3:
            begin
                num_next   = res_reg;
                op_a_next  = sat_add(m_reg, m_reg);
                op_b_next  = xi_reg;
                ret_next   = S_EXT4;
                state_next = S_DPREP;
            end

            S_EXT4:
            begin
                sums_next[4] = sat_sub(FX_ONE, res_reg);
                op_a_next    = num_reg;
                op_b_next    = num_reg;
                ret_next     = S_EXT5;
                state_next   = S_MPREP;
            end

            S_EXT5:
            begin
                sums_next[5] = res_reg;
                sums_next[3] = m_reg;
                state_next   = S_OUT;
            end

            S_MPREP:
            begin
                ua_next    = mag(op_a_reg);
                ub_next    = mag(op_b_reg);
                neg_next   = op_a_reg[DATA_W-1] ^ op_b_reg[DATA_W-1];
                acc_next   = '0;
                cnt_next   = '0;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                acc_next = acc_reg + pp;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[1:0] == 2'd3)
                    state_next = S_MFIN;
            end

            S_MFIN:
            begin
                res_next   = from_mag(neg_reg, rounded);
                state_next = ret_reg;
            end

            S_DPREP:
            begin
                if (op_b_reg == '0)
                begin
                    if (op_a_reg == '0)
                        res_next = '0;
                    else
                        res_next = op_a_reg[DATA_W-1] ? FX_MIN : FX_MAX;
                    state_next = ret_reg;
                end
                else
                begin
                    numsh_next = PROD_W'(mag(op_a_reg)) << FRAC_BITS;
                    ub_next    = mag(op_b_reg);
                    neg_next   = op_a_reg[DATA_W-1] ^ op_b_reg[DATA_W-1];
                    rem_next   = '0;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // one restoring step per cycle, quotient collects in acc
                numsh_next = numsh_reg << 1;
                if (rem_sh >= {1'b0, ub_reg})
                begin
                    rem_next = DATA_W'(rem_sh - {1'b0, ub_reg});
                    acc_next = {acc_reg[PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[DATA_W-1:0];
                    acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(PROD_W - 1))
                    state_next = S_DFIN;
            end

            S_DFIN:
            begin
                res_next   = from_mag(neg_reg, acc_reg);
                state_next = ret_reg;
            end

            S_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    for (genvar g = 0; g < NUM_VALS; g++) begin : g_pack
        assign m_tdata[DATA_W*g +: DATA_W] = sums_reg[g];
    end
    assign m_tuser = status_reg;

    // Checks
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output sides open together");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status_reg != STAT_OK) |-> (m_tdata == '0))
        else $error("error result carries nonzero data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status_reg == STAT_OK || status_reg == STAT_BRACKET
                      || status_reg == STAT_STENCIL))
        else $error("undefined status code");

    a_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BIS) |-> (lo_reg < hi_reg))
        else $error("search bracket collapsed");

    a_unit_return: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MFIN || state_reg == S_DFIN) |=> (state_reg == $past(ret_reg)))
        else $error("arithmetic unit returned to the wrong step");

endmodule
